// ===== hw/rtl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Shared constants, types and controller/datapath bundles for the group
// reverse reorder block.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 5;

    // Controller states
    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } t_grr_state;

    // Controller to datapath commands
    typedef struct packed {
        logic store;   // write the input beat into the group store
        logic start;   // this beat closes a group: set up the drain
        logic issue;   // read the next stored element for output
    } t_grr_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic trigger;   // the presented beat would close a group
        logic rd_free;   // read stage can take a new element
        logic last_left; // the next read is the final one of the group
    } t_grr_sts;

endpackage

// ===== hw/rtl/grr_in_if.sv =====
// ----------------------------------------------------------------------------
// grr_in_if
// Input channel: one sequence element per beat with an end-of-sequence flag.
// ----------------------------------------------------------------------------
interface grr_in_if import grr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    sequence_end;

    modport source (output valid, output value, output sequence_end, input ready);
    modport sink   (input valid, input value, input sequence_end, output ready);
endinterface

// ===== hw/rtl/grr_out_if.sv =====
// ----------------------------------------------------------------------------
// grr_out_if
// Output channel: one reordered element per beat with run and sequence marks.
// ----------------------------------------------------------------------------
interface grr_out_if import grr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic                    run_last;
    logic                    out_sequence_end;

    modport source (output valid, output out_value, output run_last,
                    output out_sequence_end, input ready);
    modport sink   (input valid, input out_value, input run_last,
                    input out_sequence_end, output ready);
endinterface

// ===== hw/rtl/grr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// grr_cfg_if
// Configuration write channel carrying the group size register.
// ----------------------------------------------------------------------------
interface grr_cfg_if import grr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/grr_ctrl.sv =====
// ----------------------------------------------------------------------------
// grr_ctrl
// Controller: fills the group store from the input and sequences the drain
// reads once a group closes.
// ----------------------------------------------------------------------------
module grr_ctrl import grr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_grr_sts i_sts,
    output t_grr_cmd o_cmd
);

    t_grr_state r_state;
    t_grr_state n_state;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (i_in_valid && i_sts.trigger) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.rd_free && i_sts.last_left) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.store = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.issue = 1'b0;
        case (r_state)
            ST_FILL: begin
                o_in_ready  = 1'b1;
                o_cmd.store = i_in_valid;
                o_cmd.start = i_in_valid && i_sts.trigger;
            end
            ST_DRAIN: begin
                o_cmd.issue = i_sts.rd_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/grr_dpath.sv =====
// ----------------------------------------------------------------------------
// grr_dpath
// Datapath: group store memory, fill and drain counters, registered read
// stage and output register.
// ----------------------------------------------------------------------------
module grr_dpath import grr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_grr_cmd                i_cmd,
    output t_grr_sts                o_sts,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_sequence_end,
    input  logic                    i_cfg_valid,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_run_last,
    output logic                    o_out_sequence_end
);

    logic [VAL_W-1:0] r_mem [MAX_GROUP];

    logic [CFG_W-1:0] r_group_size;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_left;
    logic [IDX_W-1:0] r_idx;
    logic             r_rev;
    logic             r_end;

    logic             r_rd_valid;
    logic [VAL_W-1:0] r_rd_data;
    logic             r_rd_last;
    logic             r_rd_end;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_last;
    logic             r_out_end;

    logic [CNT_W-1:0] eff_k;
    logic [CNT_W-1:0] n_count;
    logic             n_rev;
    logic             move;

    // Clamp group size to 1..MAX_GROUP
    always_comb begin
        if (r_group_size == '0) begin
            eff_k = CNT_W'(1);
        end else if (CNT_W'(r_group_size) > CNT_W'(MAX_GROUP)) begin
            eff_k = CNT_W'(MAX_GROUP);
        end else begin
            eff_k = CNT_W'(r_group_size);
        end
    end

    // Count after storing the presented beat; decide group close and order
    assign n_count       = r_fill + CNT_W'(1);
    assign n_rev         = (n_count >= eff_k);
    assign o_sts.trigger = n_rev || i_sequence_end;

    // Read stage hands over when the output register is empty or taken
    assign move            = r_rd_valid && (!r_out_valid || i_out_ready);
    assign o_sts.rd_free   = !r_rd_valid || move;
    assign o_sts.last_left = (r_left == CNT_W'(1));

    // Write group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    // Store the beat into the group memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_value;
        end
    end

    // Advance fill count; clear it when a group closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.store) begin
            r_fill <= i_cmd.start ? '0 : n_count;
        end
    end

    // Set up and step the drain count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.start) begin
            r_left <= n_count;
        end else if (i_cmd.issue) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rev <= n_rev;
            r_end <= i_sequence_end;
            r_idx <= n_rev ? r_fill[IDX_W-1:0] : '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_rev ? r_idx - IDX_W'(1) : r_idx + IDX_W'(1);
        end
    end

    // Registered memory read with its run marks
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_last <= (r_left == CNT_W'(1));
            r_rd_end  <= (r_left == CNT_W'(1)) && r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_rd_valid <= 1'b1;
        end else if (move) begin
            r_rd_valid <= 1'b0;
        end
    end

    // Output register: load from read stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_value <= r_rd_data;
            r_out_last  <= r_rd_last;
            r_out_end   <= r_rd_end;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_value        = signed'(r_out_value);
    assign o_run_last         = r_out_last;
    assign o_out_sequence_end = r_out_end;

endmodule

// ===== hw/rtl/group_reverse_reorder.sv =====
// ----------------------------------------------------------------------------
// group_reverse_reorder
// Buffers a stream of signed values into groups of the configured size and
// emits each full group reversed; a short group at sequence end keeps order.
//
//   channel  | dir | payload                                  | accepted when
//   ---------+-----+------------------------------------------+--------------
//   i_in     | in  | value, sequence_end                      | valid & ready
//   o_out    | out | out_value, run_last, out_sequence_end    | valid & ready
//   i_cfg    | in  | data (group size, 0 acts as 1, >16 as 16)| valid & ready
//
// Input beats are taken one per cycle while a group fills. When a group
// closes, the block drains it from the group store at one read per cycle
// unless the output stalls; input is held off during the drain, bounded by
// the single store read port. Output passes the read stage and the output
// register, two register stages; a stalled output holds the drain in place.
// Synchronous active-low reset clears control state and sets group size 1.
// ----------------------------------------------------------------------------
module group_reverse_reorder import grr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grr_in_if.sink    i_in,
    grr_out_if.source o_out,
    grr_cfg_if.sink   i_cfg
);

    t_grr_cmd cmd;
    t_grr_sts sts;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    grr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    grr_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_value            (i_in.value),
        .i_sequence_end     (i_in.sequence_end),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_data         (i_cfg.data),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_out_value        (o_out.out_value),
        .o_run_last         (o_out.run_last),
        .o_out_sequence_end (o_out.out_sequence_end)
    );

endmodule
